// ===== hdl/tagged_blob_entry_lookup_core_assert.svh =====
// assertion macros for the tagged blob entry lookup core
`ifndef TAGGED_BLOB_ENTRY_LOOKUP_CORE_ASSERT_SVH
`define TAGGED_BLOB_ENTRY_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define TBEL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tbel_pkg.sv =====
// shared constants, types and the signature byte function of the tagged blob entry lookup core
package tbel_pkg;

  localparam int MAX_KEY_BYTES_DEF = 256;

  typedef logic [1:0] status_t;
  typedef logic [2:0] phase_t;

  localparam status_t ST_FOUND     = 2'd0;
  localparam status_t ST_RAW       = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_MALFORMED = 2'd3;

  localparam phase_t PH_SIG     = 3'd0;
  localparam phase_t PH_RAW     = 3'd1;
  localparam phase_t PH_KEYLEN  = 3'd2;
  localparam phase_t PH_DATALEN = 3'd3;
  localparam phase_t PH_KEY     = 3'd4;
  localparam phase_t PH_DATA    = 3'd5;

  localparam logic [7:0] SIG_CHAR0 = 8'h4E;
  localparam logic [7:0] SIG_CHAR1 = 8'h56;
  localparam logic [7:0] SIG_CHAR2 = 8'h53;
  localparam logic [7:0] SIG_CHAR3 = 8'h50;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = SIG_CHAR0;
      2'd1:    b = SIG_CHAR1;
      2'd2:    b = SIG_CHAR2;
      default: b = SIG_CHAR3;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/tbel_in_if.sv =====
// input channel: key or blob bytes
interface tbel_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       is_first;
  logic       is_last;

  modport source (output valid, action, data_byte, is_first, is_last, input ready);
  modport sink   (input valid, action, data_byte, is_first, is_last, output ready);
endinterface

// ===== hdl/tbel_out_if.sv =====
// result channel: lookup status, data offset and size
interface tbel_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source (output valid, status, data_offset, data_size, input ready);
  modport sink   (input valid, status, data_offset, data_size, output ready);
endinterface

// ===== hdl/tagged_blob_entry_lookup_core.sv =====
// top level: keyed entry lookup in a signed tag-length container, one byte per item
//
// in_ch carries one byte per item: action 0 loads the requested key (is_first
// restarts it), action 1 feeds the container blob (is_first restarts the parse,
// is_last marks its final byte). out_ch returns at most one result per blob:
// entry found with data offset and size, raw whole blob, not found or malformed.
// A result appears on out_ch in the cycle after the item that completes it is
// accepted; items that complete nothing produce no result.
// Throughput is one item per cycle while out_ch does not stall: each byte does
// one compare and one counter update, and the key memory is read one byte ahead
// through a registered port so that the compare byte is ready when the next key byte arrives.
// Reset clears the key length, the parser and the result valid flag; the key
// memory keeps whatever it held and needs no clearing pass.
// When out_ch stalls with a result pending, in_ch.ready drops until the result
// is taken; the pending result holds steady.
`include "tagged_blob_entry_lookup_core_assert.svh"

module tagged_blob_entry_lookup_core
  import tbel_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tbel_in_if.sink    in_ch,
  tbel_out_if.source out_ch
);

  localparam int AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KLW-1:0] MAX_LEN = KLW'(MAX_KEY_BYTES);

  logic           in_fire, blob_fire, key_fire;
  logic [7:0]     key_rd;
  logic [KLW-1:0] key_len;
  logic           key_too_long, key_empty;

  phase_t         phase_r, phase_nxt;
  logic [31:0]    pos_r, pos_nxt;
  logic [31:0]    hdr_r, hdr_nxt;
  logic [1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]    ekl_r, ekl_nxt;
  logic [31:0]    edl_r, edl_nxt;
  logic [31:0]    rem_r, rem_nxt;
  logic [31:0]    dstart_r, dstart_nxt;
  logic [KLW-1:0] kidx_r, kidx_nxt;
  logic           ksm_r, ksm_nxt;
  logic           ag_r, ag_nxt;

  logic           res_v;
  status_t        res_status;
  logic [31:0]    res_off, res_size;

  logic           out_valid_r;
  status_t        out_status_r;
  logic [31:0]    out_off_r, out_size_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign blob_fire   = in_fire && in_ch.action;
  assign key_fire    = in_fire && !in_ch.action;
  assign key_empty   = (key_len == '0) && !key_too_long;

  tbel_key_store #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (key_fire),
    .first       (in_ch.is_first),
    .data_byte   (in_ch.data_byte),
    .rd_addr     (kidx_nxt[AW-1:0]),
    .rd_data     (key_rd),
    .key_len     (key_len),
    .key_too_long(key_too_long)
  );

  always_comb begin
    logic [31:0] idx;
    logic [31:0] hdr_val;
    logic [31:0] rem_dec;

    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    hdr_cnt_nxt = hdr_cnt_r;
    ekl_nxt     = ekl_r;
    edl_nxt     = edl_r;
    rem_nxt     = rem_r;
    dstart_nxt  = dstart_r;
    kidx_nxt    = kidx_r;
    ksm_nxt     = ksm_r;
    ag_nxt      = ag_r;
    res_v       = 1'b0;
    res_status  = ST_NOT_FOUND;
    res_off     = '0;
    res_size    = '0;
    idx         = pos_r;
    hdr_val     = {in_ch.data_byte, hdr_r[31:8]};
    rem_dec     = rem_r - 32'd1;

    if (blob_fire) begin
      if (in_ch.is_first) begin
        phase_nxt   = PH_SIG;
        pos_nxt     = '0;
        hdr_nxt     = '0;
        hdr_cnt_nxt = '0;
        ekl_nxt     = '0;
        edl_nxt     = '0;
        rem_nxt     = '0;
        ksm_nxt     = 1'b1;
        ag_nxt      = 1'b0;
      end
      if (!ag_nxt) begin
        if (pos_nxt == '1) begin
          res_v      = 1'b1;
          res_status = ST_MALFORMED;
        end else begin
          idx     = pos_nxt;
          pos_nxt = pos_nxt + 32'd1;
          hdr_val = {in_ch.data_byte, hdr_nxt[31:8]};
          rem_dec = rem_nxt - 32'd1;
          case (phase_nxt)
            PH_SIG: begin
              if (in_ch.data_byte != sig_byte(idx[1:0])) begin
                ksm_nxt = 1'b0;
              end
              if (idx == 32'd3) begin
                if (ksm_nxt) begin
                  phase_nxt   = PH_KEYLEN;
                  hdr_cnt_nxt = '0;
                  hdr_nxt     = '0;
                end else if (key_empty) begin
                  phase_nxt = PH_RAW;
                end else begin
                  res_v      = 1'b1;
                  res_status = ST_MALFORMED;
                end
              end
            end
            PH_KEYLEN, PH_DATALEN: begin
              hdr_nxt     = hdr_val;
              hdr_cnt_nxt = hdr_cnt_nxt + 2'd1;
              if (hdr_cnt_nxt == 2'd0) begin
                hdr_nxt = '0;
                if (phase_nxt == PH_KEYLEN) begin
                  ekl_nxt   = hdr_val;
                  phase_nxt = PH_DATALEN;
                end else begin
                  edl_nxt = hdr_val;
                  if (hdr_val == '0) begin
                    res_v      = 1'b1;
                    res_status = ST_MALFORMED;
                  end else begin
                    ksm_nxt = !key_too_long && (ekl_nxt == 32'(key_len));
                    if (ekl_nxt == '0) begin
                      phase_nxt  = PH_DATA;
                      rem_nxt    = hdr_val;
                      dstart_nxt = pos_nxt;
                    end else begin
                      phase_nxt = PH_KEY;
                      rem_nxt   = ekl_nxt;
                      kidx_nxt  = '0;
                    end
                  end
                end
              end
            end
            PH_KEY: begin
              if (ksm_nxt && ((kidx_r >= key_len) || (kidx_r == MAX_LEN) ||
                              (key_rd != in_ch.data_byte))) begin
                ksm_nxt = 1'b0;
              end
              if (kidx_r != MAX_LEN) begin
                kidx_nxt = kidx_r + KLW'(1);
              end
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                phase_nxt  = PH_DATA;
                rem_nxt    = edl_nxt;
                dstart_nxt = pos_nxt;
              end
            end
            PH_DATA: begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                if (ksm_nxt) begin
                  res_v      = 1'b1;
                  res_status = ST_FOUND;
                  res_off    = dstart_nxt;
                  res_size   = edl_nxt;
                end else begin
                  phase_nxt   = PH_KEYLEN;
                  hdr_cnt_nxt = '0;
                  hdr_nxt     = '0;
                end
              end
            end
            default: begin
            end
          endcase
          if (!res_v && in_ch.is_last) begin
            res_v = 1'b1;
            if (phase_nxt == PH_SIG) begin
              if (key_empty) begin
                res_status = ST_RAW;
                res_size   = pos_nxt;
              end else begin
                res_status = ST_MALFORMED;
              end
            end else if (phase_nxt == PH_RAW) begin
              res_status = ST_RAW;
              res_size   = pos_nxt;
            end else if ((phase_nxt == PH_KEYLEN) && (hdr_cnt_nxt == 2'd0)) begin
              res_status = ST_NOT_FOUND;
            end else begin
              res_status = ST_MALFORMED;
            end
          end
        end
      end
      if (res_v) begin
        ag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      pos_r     <= '0;
      hdr_r     <= '0;
      hdr_cnt_r <= '0;
      ekl_r     <= '0;
      edl_r     <= '0;
      rem_r     <= '0;
      dstart_r  <= '0;
      kidx_r    <= '0;
      ksm_r     <= 1'b0;
      ag_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      hdr_r     <= hdr_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      ekl_r     <= ekl_nxt;
      edl_r     <= edl_nxt;
      rem_r     <= rem_nxt;
      dstart_r  <= dstart_nxt;
      kidx_r    <= kidx_nxt;
      ksm_r     <= ksm_nxt;
      ag_r      <= ag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (blob_fire && res_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blob_fire && res_v) begin
      out_status_r <= res_status;
      out_off_r    <= res_off;
      out_size_r   <= res_size;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_offset = out_off_r;
  assign out_ch.data_size   = out_size_r;

  `TBEL_ASSERT_NOW(a_zero_fields, out_valid_r && ((out_status_r == ST_NOT_FOUND) || (out_status_r == ST_MALFORMED)), (out_off_r == '0) && (out_size_r == '0), "nonzero fields on miss")
  `TBEL_ASSERT_NEXT(a_answer_latched, blob_fire && res_v, ag_r && out_valid_r, "answer not latched")
  `TBEL_ASSERT_NOW(a_one_answer, ag_r && blob_fire && !in_ch.is_first, !res_v, "second answer in blob")

endmodule

// ===== hdl/tbel_key_store.sv =====
// requested key memory with length tracking and read-after-write bypass
module tbel_key_store
  import tbel_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic                                 first,
  input  logic [7:0]                           data_byte,
  input  logic [((MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1)-1:0] rd_addr,
  output logic [7:0]                           rd_data,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]   key_len,
  output logic                                 key_too_long
);

  localparam int AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KLW-1:0] MAX_LEN = KLW'(MAX_KEY_BYTES);

  logic [7:0]     mem [MAX_KEY_BYTES];
  logic [7:0]     rd_data_r;
  logic [KLW-1:0] len_r, len_nxt, len_eff;
  logic           too_long_r, too_long_nxt;
  logic           we;
  logic [AW-1:0]  wa;

  always_comb begin
    len_eff      = first ? '0 : len_r;
    we           = load && (len_eff < MAX_LEN);
    wa           = len_eff[AW-1:0];
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    if (load) begin
      too_long_nxt = first ? 1'b0 : too_long_r;
      len_nxt      = len_eff;
      if (we) begin
        len_nxt = len_eff + KLW'(1);
      end else begin
        too_long_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (wa == rd_addr)) begin
      rd_data_r <= data_byte;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data      = rd_data_r;
  assign key_len      = len_r;
  assign key_too_long = too_long_r;

endmodule
